### sv/bsrp_pkg.sv
package bsrp_pkg;

  // reply framing
  localparam logic [7:0] HDR0      = 8'hFF;
  localparam logic [7:0] HDR1      = 8'hF5;
  localparam int         MIN_BYTES = 6;
  // at most this many result transactions per reply
  localparam int         RESULT_CAP = 8;

  // one accepted reply, handed from the parser to the result side
  typedef struct packed {
    logic [7:0]  node_id;
    logic [7:0]  status_byte;
    logic [3:0]  param_count;
    logic        no_params;
    logic [2:0]  last_idx;
    logic [31:0] valid_total;
    logic        bank;
  } reply_t;

endpackage

### sv/bus_servo_response_parser.sv
// Bus servo reply parser. Takes one received byte per transaction, tlast on the last
// byte of a burst, and checks each burst for the FF F5 header, at least 6 bytes, at
// least 4 plus the length byte, and the inverted 8-bit sum over ID, length, status and
// parameters. Bytes past RX_DEPTH are dropped. A good reply gives one result
// transaction per stored parameter byte (one when there are none, at most 8), tlast on
// the final one; a bad reply gives none. Bytes are taken one per cycle while no burst end
// waits, and results leave one per cycle while out_tready is high. The final byte of every
// burst, good or bad, waits in the input register until the result side is idle or is
// loading the last result of the previous good reply; the parameter store is double
// banked so the next burst fills while the last is read out.
module bus_servo_response_parser import bsrp_pkg::*; #(
  parameter int RX_DEPTH   = 16,
  parameter int MAX_PARAMS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // node_id, status_byte, param_count, param_index,
                                  // param_byte, valid_total, zero fill
  output logic        out_tlast
);

  localparam int POS_W = $clog2(RX_DEPTH + 1);
  localparam int PA_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CNT_W = $clog2(MAX_PARAMS + 1);

  // input register
  logic        in_full_r;
  logic [7:0]  in_byte_r;
  logic        in_end_r;

  // burst state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic             cs_ok_r, cs_ok_nxt;
  logic             wr_bank_r;
  logic [31:0]      count_r;

  logic                  em_free;
  logic                  in_go;
  logic                  take;
  logic                  reply_ok;
  logic [7:0]            n_params;
  logic [8:0]            cs_pos;
  logic [8:0]            p9;
  logic [POS_W+PA_W-1:0] off_ext;
  logic                  wr_en;
  logic [PA_W-1:0]       wr_addr;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W+3:0]      cnt_ext;
  reply_t                reply;

  // input register advances unless a burst end must wait for the result side
  assign in_go     = in_full_r && (!in_end_r || em_free);
  assign in_tready = !in_full_r || in_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_full_r <= 1'b1;
    end else if (in_go) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  // byte parse and reply verdict
  always_comb begin
    pos_nxt    = pos_r;
    hdr_ok_nxt = hdr_ok_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    status_nxt = status_r;
    sum_nxt    = sum_r;
    cs_ok_nxt  = cs_ok_r;
    wr_en      = 1'b0;
    p9         = 9'(pos_r);
    off_ext    = {{PA_W{1'b0}}, pos_r - POS_W'(5)};
    wr_addr    = off_ext[PA_W-1:0];

    if (pos_r < POS_W'(RX_DEPTH)) begin
      pos_nxt = pos_r + POS_W'(1);
      if (p9 == 9'd0 && in_byte_r != HDR0) begin
        hdr_ok_nxt = 1'b0;
      end
      if (p9 == 9'd1 && in_byte_r != HDR1) begin
        hdr_ok_nxt = 1'b0;
      end
      if (p9 == 9'd2) begin
        id_nxt = in_byte_r;
      end
      if (p9 == 9'd3) begin
        len_nxt = in_byte_r;
      end
      if (p9 == 9'd4) begin
        status_nxt = in_byte_r;
      end
    end

    n_params = (len_nxt >= 8'd2) ? len_nxt - 8'd2 : 8'd0;
    cs_pos   = 9'd5 + 9'(n_params);

    if (pos_r < POS_W'(RX_DEPTH)) begin
      if (p9 >= 9'd2 && p9 < cs_pos) begin
        sum_nxt = sum_r + in_byte_r;
      end
      if (p9 >= 9'd5 && p9 < cs_pos && off_ext < (POS_W+PA_W)'(MAX_PARAMS)) begin
        wr_en = in_go;
      end
      if (p9 >= 9'd5 && p9 == cs_pos) begin
        cs_ok_nxt = (~sum_r == in_byte_r);
      end
    end

    reply_ok = hdr_ok_nxt && cs_ok_nxt && (9'(pos_nxt) >= 9'(MIN_BYTES))
               && (9'(pos_nxt) >= 9'd4 + 9'(len_nxt));
    take     = in_go && in_end_r && reply_ok;

    // parameter count clamped to the store size
    cnt     = (n_params > 8'(MAX_PARAMS)) ? CNT_W'(MAX_PARAMS) : CNT_W'(n_params);
    cnt_ext = {4'd0, cnt};

    reply.node_id     = id_nxt;
    reply.status_byte = status_nxt;
    reply.param_count = cnt_ext[3:0];
    reply.no_params   = (cnt == '0);
    if (cnt == '0) begin
      reply.last_idx = 3'd0;
    end else if (9'(cnt) >= 9'(RESULT_CAP)) begin
      reply.last_idx = 3'(RESULT_CAP - 1);
    end else begin
      reply.last_idx = 3'(9'(cnt) - 9'd1);
    end
    reply.valid_total = count_r + 32'd1;
    reply.bank        = wr_bank_r;
  end

  // burst state, cleared at each burst end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      hdr_ok_r <= 1'b1;
      id_r     <= 8'd0;
      len_r    <= 8'd0;
      status_r <= 8'd0;
      sum_r    <= 8'd0;
      cs_ok_r  <= 1'b0;
    end else if (in_go) begin
      if (in_end_r) begin
        pos_r    <= '0;
        hdr_ok_r <= 1'b1;
        id_r     <= 8'd0;
        len_r    <= 8'd0;
        status_r <= 8'd0;
        sum_r    <= 8'd0;
        cs_ok_r  <= 1'b0;
      end else begin
        pos_r    <= pos_nxt;
        hdr_ok_r <= hdr_ok_nxt;
        id_r     <= id_nxt;
        len_r    <= len_nxt;
        status_r <= status_nxt;
        sum_r    <= sum_nxt;
        cs_ok_r  <= cs_ok_nxt;
      end
    end
  end

  // good reply count and store bank swap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 32'd0;
      wr_bank_r <= 1'b0;
    end else if (take) begin
      count_r   <= count_r + 32'd1;
      wr_bank_r <= !wr_bank_r;
    end
  end

  bsrp_emit #(
    .MAX_PARAMS (MAX_PARAMS),
    .PA_W       (PA_W)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_bank    (wr_bank_r),
    .wr_addr    (wr_addr),
    .wr_data    (in_byte_r),
    .take       (take),
    .reply      (reply),
    .free       (em_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### sv/bsrp_emit.sv
module bsrp_emit import bsrp_pkg::*; #(
  parameter int MAX_PARAMS = 8,
  parameter int PA_W       = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  // parameter store write port
  input  logic            wr_en,
  input  logic            wr_bank,
  input  logic [PA_W-1:0] wr_addr,
  input  logic [7:0]      wr_data,
  // new reply
  input  logic            take,
  input  reply_t          reply,
  output logic            free,
  // result stream
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [63:0]     out_tdata,  // node_id, status_byte, param_count, param_index,
                                      // param_byte, valid_total, zero fill
  output logic            out_tlast
);

  // two banks: one being filled by the parser, one being read out
  logic [7:0] mem [2][MAX_PARAMS];

  logic            busy_r;
  reply_t          meta_r;
  logic [2:0]      idx_r;
  logic            out_valid_r;
  logic [7:0]      o_id_r;
  logic [7:0]      o_status_r;
  logic [3:0]      o_count_r;
  logic [2:0]      o_idx_r;
  logic            o_zero_r;
  logic [31:0]     o_total_r;
  logic            o_last_r;
  logic [7:0]      rd_r;

  logic            out_load;
  logic            at_last;
  logic [PA_W+2:0] idx_ext;
  logic [PA_W-1:0] rd_addr;

  // while a reply is read out, the result register loads whenever it is empty or being taken
  always_comb begin
    out_load = busy_r && (!out_valid_r || out_tready);
    at_last  = (idx_r == meta_r.last_idx);
    free     = !busy_r || (out_load && at_last);
    idx_ext  = {{PA_W{1'b0}}, idx_r};
    rd_addr  = idx_ext[PA_W-1:0];
  end

  // store write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_bank][wr_addr] <= wr_data;
    end
  end

  // reply being read out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (take) begin
      busy_r <= 1'b1;
      idx_r  <= 3'd0;
    end else if (out_load) begin
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      meta_r <= reply;
    end
  end

  // result register with registered store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_id_r     <= meta_r.node_id;
      o_status_r <= meta_r.status_byte;
      o_count_r  <= meta_r.param_count;
      o_idx_r    <= idx_r;
      o_zero_r   <= meta_r.no_params;
      o_total_r  <= meta_r.valid_total;
      o_last_r   <= at_last;
      rd_r       <= mem[meta_r.bank][rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {1'b0, o_total_r, (o_zero_r ? 8'd0 : rd_r), o_idx_r, o_count_r,
                       o_status_r, o_id_r};

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bsrp_pkg::*;

  localparam int RX_DEPTH   = 16;
  localparam int MAX_PARAMS = 8;

  // one byte waiting to be sent, with a flag to hold it until all results are in
  typedef struct {
    logic [7:0] data;
    logic       eob;
    logic       hold;
  } rx_beat_t;

  // one predicted result transaction
  typedef struct packed {
    logic [7:0]  node_id;
    logic [7:0]  status_byte;
    logic [3:0]  param_count;
    logic [2:0]  param_index;
    logic [7:0]  param_byte;
    logic [31:0] valid_total;
    logic        last;
  } reply_beat_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;   // rx_byte
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;             // node_id, status_byte, param_count, param_index,
                                      // param_byte, valid_total, zero fill
  logic        out_tlast;

  rx_beat_t    rx_stream[$];
  reply_beat_t parsed_results[$];
  logic [7:0]  frame[$];

  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;
  int   in_gap   = 0;
  int   out_wait = 0;
  bit   in_calm  = 1'b0;
  bit   out_calm = 1'b0;
  int   bytes_queued = 0;
  int   bytes_taken  = 0;
  int   fail_count   = 0;

  // predictor state
  int          pos_cnt;
  logic        hdr_ok;
  logic [7:0]  id_seen;
  int          len_seen;
  logic [7:0]  status_seen;
  logic [7:0]  sum_acc;
  logic        cs_ok;
  logic [7:0]  param_mem [MAX_PARAMS];
  logic [31:0] good_replies;

  bus_servo_response_parser #(
    .RX_DEPTH   (RX_DEPTH),
    .MAX_PARAMS (MAX_PARAMS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // clear the per-burst state
  function automatic void clear_burst();
    pos_cnt     = 0;
    hdr_ok      = 1'b1;
    id_seen     = 8'h00;
    len_seen    = 0;
    status_seen = 8'h00;
    sum_acc     = 8'h00;
    cs_ok       = 1'b0;
  endfunction

  // take one received byte, queue the results of a good reply at burst end
  function automatic void parse_byte(logic [7:0] b, logic eob);
    int          p;
    int          n_par;
    int          cs_at;
    int          cnt;
    int          items;
    logic [7:0]  inv_sum;
    reply_beat_t r;
    p = pos_cnt;
    if (p < RX_DEPTH) begin
      pos_cnt = p + 1;
      if (p == 0 && b != HDR0) hdr_ok = 1'b0;
      if (p == 1 && b != HDR1) hdr_ok = 1'b0;
      if (p == 2) id_seen = b;
      if (p == 3) len_seen = b;
      if (p == 4) status_seen = b;
      n_par = (len_seen >= 2) ? len_seen - 2 : 0;
      cs_at = 5 + n_par;
      if (p >= 2 && p < cs_at) sum_acc = sum_acc + b;
      if (p >= 5 && p < cs_at && p - 5 < MAX_PARAMS) param_mem[p - 5] = b;
      inv_sum = ~sum_acc;
      if (p >= 5 && p == cs_at) cs_ok = (inv_sum == b);
    end
    if (eob) begin
      if (pos_cnt >= MIN_BYTES && hdr_ok && pos_cnt >= 4 + len_seen && cs_ok) begin
        good_replies = good_replies + 1;
        n_par = (len_seen >= 2) ? len_seen - 2 : 0;
        cnt   = (n_par > MAX_PARAMS) ? MAX_PARAMS : n_par;
        items = (cnt == 0) ? 1 : cnt;
        if (items > RESULT_CAP) items = RESULT_CAP;
        for (int i = 0; i < items; i++) begin
          r.node_id     = id_seen;
          r.status_byte = status_seen;
          r.param_count = 4'(cnt);
          r.param_index = 3'(i);
          r.param_byte  = (cnt == 0) ? 8'h00 : param_mem[i];
          r.valid_total = good_replies;
          r.last        = (i + 1 == items);
          parsed_results.push_back(r);
        end
      end
      clear_burst();
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // build a well-formed reply into frame: FF F5 id len status params cs
  function automatic void make_reply(logic [7:0] id, logic [7:0] len, logic [7:0] status);
    logic [7:0] sum;
    logic [7:0] pb;
    int         n;
    frame.delete();
    frame.push_back(HDR0);
    frame.push_back(HDR1);
    frame.push_back(id);
    frame.push_back(len);
    frame.push_back(status);
    sum = id + len + status;
    n = (len >= 2) ? len - 2 : 0;
    for (int i = 0; i < n; i++) begin
      pb = 8'($urandom_range(0, 255));
      frame.push_back(pb);
      sum = sum + pb;
    end
    frame.push_back(~sum);
  endfunction

  function automatic void send_frame(logic hold);
    rx_beat_t t;
    for (int i = 0; i < frame.size(); i++) begin
      t.data = frame[i];
      t.eob  = (i == frame.size() - 1);
      t.hold = hold && (i == 0);
      rx_stream.push_back(t);
    end
    bytes_queued += frame.size();
  endfunction

  // handshake sampling, result checking and prediction
  always @(posedge clk) begin
    reply_beat_t e;
    in_fire  <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (parsed_results.size() == 0) begin
        $error("result transaction with nothing expected: tdata %0h", out_tdata);
        fail_count++;
      end else begin
        e = parsed_results.pop_front();
        check_field("node_id", 32'(e.node_id), 32'(out_tdata[7:0]));
        check_field("status_byte", 32'(e.status_byte), 32'(out_tdata[15:8]));
        check_field("param_count", 32'(e.param_count), 32'(out_tdata[19:16]));
        check_field("param_index", 32'(e.param_index), 32'(out_tdata[22:20]));
        check_field("param_byte", 32'(e.param_byte), 32'(out_tdata[30:23]));
        check_field("valid_total", e.valid_total, out_tdata[62:31]);
        check_field("last", 32'(e.last), 32'(out_tlast));
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      parse_byte(in_tdata, in_tlast);
      bytes_taken++;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      // hold the current transaction
    end else if (in_gap != 0) begin
      in_tvalid <= 1'b0;
      in_gap    <= in_gap - 1;
    end else if (rx_stream.size() != 0 &&
                 !(rx_stream[0].hold && parsed_results.size() != 0)) begin
      in_tvalid <= 1'b1;
      in_tdata  <= rx_stream[0].data;
      in_tlast  <= rx_stream[0].eob;
      void'(rx_stream.pop_front());
      if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
      in_gap <= in_calm ? 0 : $urandom_range(0, 8);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    int wait_n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_wait   <= 0;
    end else begin
      wait_n = out_wait;
      if (out_fire) begin
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        wait_n = out_calm ? 0 : $urandom_range(0, 8);
      end
      if (wait_n != 0) begin
        out_tready <= 1'b0;
        out_wait   <= wait_n - 1;
      end else begin
        out_tready <= 1'b1;
        out_wait   <= 0;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int rand_bytes;
    int good_frames;
    int kind;
    int idx;
    int keep;
    logic first_hold;
    clear_burst();
    good_replies = 32'd0;
    for (int i = 0; i < MAX_PARAMS; i++) param_mem[i] = 8'h00;

    // no parameters
    make_reply(8'h00, 8'd2, 8'hFF);
    send_frame(1'b0);
    // length byte below two
    make_reply(8'hFF, 8'd1, 8'h00);
    send_frame(1'b0);
    // many parameters in a long burst, extra bytes dropped
    make_reply(8'h7E, 8'd12, 8'h5A);
    repeat (3) frame.push_back(8'($urandom_range(0, 255)));
    send_frame(1'b0);
    // broken header
    make_reply(8'h01, 8'd2, 8'h00);
    frame[1] = 8'hF4;
    send_frame(1'b0);
    // wrong checksum, sent only once the result side has drained
    make_reply(8'h80, 8'd0, 8'h80);
    frame[5] = ~frame[5];
    send_frame(1'b1);
    // single byte burst
    frame.delete();
    frame.push_back(HDR0);
    send_frame(1'b0);

    // random bursts, mostly well-formed
    rand_bytes  = 0;
    good_frames = 0;
    first_hold  = 1'b1;
    while (rand_bytes < 100 || good_frames < 5) begin
      kind = $urandom_range(0, 9);
      make_reply(8'($urandom_range(0, 255)), 8'($urandom_range(0, 12)),
                 8'($urandom_range(0, 255)));
      if (kind <= 5) begin
        good_frames++;
        if (kind == 5) repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
      end else if (kind == 6) begin
        idx = $urandom_range(0, frame.size() - 1);
        frame[idx] = frame[idx] ^ (8'h01 << $urandom_range(0, 7));
      end else if (kind == 7) begin
        keep = $urandom_range(1, frame.size());
        while (frame.size() > keep) void'(frame.pop_back());
      end else if (kind == 8) begin
        frame.delete();
        repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom_range(0, 255)));
      end else begin
        make_reply(8'($urandom_range(0, 255)), 8'($urandom_range(13, 255)),
                   8'($urandom_range(0, 255)));
        keep = $urandom_range(6, 20);
        while (frame.size() > keep) void'(frame.pop_back());
      end
      rand_bytes += frame.size();
      send_frame(first_hold || $urandom_range(0, 7) == 0);
      first_hold = 1'b0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (bytes_taken == bytes_queued);
    wait (parsed_results.size() == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && parsed_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
